// ===== hw/rtl/q2rm_pkg.sv =====
`timescale 1ns / 1ps
package q2rm_pkg;
	localparam int CompBits = 16;
	localparam int FracBits = 14;
	localparam int QBits    = FracBits + 2;
	localparam int NBits    = 2 * CompBits + 2;
	localparam int NumEnt   = 9;

	typedef logic signed [CompBits-1:0] comp_t;
	typedef logic signed [15:0] entry_t;

	typedef struct packed {
		comp_t quat_x;
		comp_t quat_y;
		comp_t quat_z;
		comp_t quat_w;
	} quat_t;

	typedef struct packed {
		entry_t m_r0_c0;
		entry_t m_r0_c1;
		entry_t m_r0_c2;
		entry_t m_r1_c0;
		entry_t m_r1_c1;
		entry_t m_r1_c2;
		entry_t m_r2_c0;
		entry_t m_r2_c1;
		entry_t m_r2_c2;
		logic   invalid;
	} mat_t;
endpackage

// ===== hw/rtl/q2rm_if.sv =====
`timescale 1ns / 1ps
interface q2rm_quat_if import q2rm_pkg::*; ();
	logic  valid;
	logic  ready;
	quat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface q2rm_mat_if import q2rm_pkg::*; ();
	logic valid;
	logic ready;
	mat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/q2rm_num.sv =====
`timescale 1ns / 1ps
// Form the squared norm and the nine signed numerators over two stages.
module q2rm_num import q2rm_pkg::*; (
	input  logic clk,
	input  logic adv,
	input  quat_t q,
	output logic signed [NBits:0] num [NumEnt],
	output logic [NBits-1:0] n
);
	logic signed [2*CompBits-1:0] p_s1 [10];
	comp_t x, y, z, w;

	assign x = q.quat_x;
	assign y = q.quat_y;
	assign z = q.quat_z;
	assign w = q.quat_w;

	// Register all ten component products
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1[0] <= x * x;
			p_s1[1] <= y * y;
			p_s1[2] <= z * z;
			p_s1[3] <= w * w;
			p_s1[4] <= x * y;
			p_s1[5] <= z * w;
			p_s1[6] <= x * z;
			p_s1[7] <= y * w;
			p_s1[8] <= y * z;
			p_s1[9] <= x * w;
		end
	end

	logic signed [NBits:0] e [10];
	logic signed [NBits:0] nn;
	always_comb begin
		for (int i = 0; i < 10; i++)
			e[i] = (NBits+1)'(p_s1[i]);
		nn = e[0] + e[1] + e[2] + e[3];
	end

	// Combine products into numerators
	always_ff @(posedge clk) begin
		if (adv) begin
			n      <= NBits'(nn);
			num[0] <= nn - ((e[1] + e[2]) <<< 1);
			num[1] <= (e[4] - e[5]) <<< 1;
			num[2] <= (e[6] + e[7]) <<< 1;
			num[3] <= (e[4] + e[5]) <<< 1;
			num[4] <= nn - ((e[0] + e[2]) <<< 1);
			num[5] <= (e[8] - e[9]) <<< 1;
			num[6] <= (e[6] - e[7]) <<< 1;
			num[7] <= (e[8] + e[9]) <<< 1;
			num[8] <= nn - ((e[0] + e[1]) <<< 1);
		end
	end
endmodule

// ===== hw/rtl/q2rm_div.sv =====
`timescale 1ns / 1ps
// Restoring divider lanes, one quotient bit per stage, round and saturate.
module q2rm_div import q2rm_pkg::*; (
	input  logic clk,
	input  logic adv,
	input  logic signed [NBits:0] num [NumEnt],
	input  logic [NBits-1:0] n,
	output entry_t ent [NumEnt],
	output logic inv
);
	logic [NBits+1:0] r_in [NumEnt];
	logic             ng_in [NumEnt];
	logic [NBits+1:0] r_s [1:QBits][NumEnt];
	logic [QBits-1:0] qt_s [1:QBits][NumEnt];
	logic             ng_s [1:QBits][NumEnt];
	logic [NBits-1:0] d_s [1:QBits];

	// Load magnitudes and signs
	always_comb begin
		for (int j = 0; j < NumEnt; j++) begin
			ng_in[j] = num[j][NBits];
			r_in[j]  = (NBits+2)'(num[j][NBits] ? -num[j] : num[j]);
		end
	end

	// One quotient bit per register stage
	for (genvar k = 0; k < QBits; k++) begin : g_stage
		logic [NBits+1:0] r_c [NumEnt];
		logic [QBits-1:0] qt_c [NumEnt];
		logic             ng_c [NumEnt];
		logic [NBits-1:0] d_c;

		if (k == 0) begin : g_load
			assign r_c  = r_in;
			assign qt_c = '{default: '0};
			assign ng_c = ng_in;
			assign d_c  = n;
		end else begin : g_next
			assign r_c  = r_s[k];
			assign qt_c = qt_s[k];
			assign ng_c = ng_s[k];
			assign d_c  = d_s[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				d_s[k+1] <= d_c;
				for (int j = 0; j < NumEnt; j++) begin
					ng_s[k+1][j] <= ng_c[j];
					if (r_c[j] >= (NBits+2)'(d_c)) begin
						r_s[k+1][j]  <= (r_c[j] - (NBits+2)'(d_c)) << 1;
						qt_s[k+1][j] <= {qt_c[j][QBits-2:0], 1'b1};
					end else begin
						r_s[k+1][j]  <= r_c[j] << 1;
						qt_s[k+1][j] <= {qt_c[j][QBits-2:0], 1'b0};
					end
				end
			end
		end
	end

	// Round, clamp, apply sign
	logic [QBits:0] rq [NumEnt];
	logic [15:0] mg [NumEnt];
	always_comb begin
		inv = (d_s[QBits] == '0);
		for (int j = 0; j < NumEnt; j++) begin
			rq[j] = ({1'b0, qt_s[QBits][j]} + 1'b1) >> 1;
			mg[j] = (rq[j] > (QBits+1)'(1 << FracBits)) ? 16'(1 << FracBits) : 16'(rq[j]);
			ent[j] = inv ? '0 : (ng_s[QBits][j] ? -$signed(mg[j]) : $signed(mg[j]));
		end
	end
endmodule

// ===== hw/rtl/quaternion_to_rotation_matrix_unit.sv =====
`timescale 1ns / 1ps
// Quaternion to 3x3 rotation matrix.
// Channel quat (sink): quat_x/y/z/w, signed Q1.14, valid/ready handshake.
// Channel mat (source): nine matrix entries in row order, signed Q1.14
//   within +-1.0, plus invalid, set for a zero quaternion (entries zero).
// Pipeline: the accepting edge loads the products, then come the
//   numerator register, 16 restoring divider stages (one quotient bit
//   each) and the output register, which drives result valid.
// Throughput: one item per cycle unless stalled; every stage is a register slice.
// Stall: the whole pipe advances only when the output register is empty
//   or being taken, so a stalled receiver holds every item in place and
//   ready drops; nothing is lost or repeated.
// Reset: arst_n clears all valid bits; payload registers are not reset.
module quaternion_to_rotation_matrix_unit import q2rm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	q2rm_quat_if.sink   quat,
	q2rm_mat_if.source  mat
);
	localparam int Depth = QBits + 2;

	logic [Depth-1:0] vld_q;
	logic out_vld_q;
	mat_t out_q;
	logic adv;
	logic signed [NBits:0] num [NumEnt];
	logic [NBits-1:0] n;
	entry_t ent [NumEnt];
	logic inv;

	assign adv = !out_vld_q || mat.ready;
	assign quat.ready = adv;
	assign mat.valid = out_vld_q;
	assign mat.data = out_q;

	q2rm_num u_num (.clk, .adv, .q(quat.data), .num, .n);
	q2rm_div u_div (.clk, .adv, .num, .n, .ent, .inv);

	// Advance valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= {vld_q[Depth-2:0], quat.valid};
			out_vld_q <= vld_q[Depth-1];
		end
	end

	// Hold the finished item for the receiver
	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= '{ent[0], ent[1], ent[2], ent[3], ent[4], ent[5],
				ent[6], ent[7], ent[8], inv};
		end
	end
endmodule
